### hdl/uart_register_model_top_defines.svh
// ----------------------------------------------------------------------------
// UART register model assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_MODEL_TOP_DEFINES_SVH
`define UART_REGISTER_MODEL_TOP_DEFINES_SVH

// same-cycle implication
`define URM_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("urm assertion failed");

// next-cycle implication
`define URM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("urm assertion failed");

`endif

### hdl/urm_pkg.sv
// ----------------------------------------------------------------------------
// UART register model package
// Field widths, action and register codes, fixed readback values.
// ----------------------------------------------------------------------------
`default_nettype none

package urm_pkg;

  localparam int unsigned ActionW = 2;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned ByteW   = 8;

  typedef enum logic [ActionW-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RX    = 2'd2,
    ACT_POLL  = 2'd3
  } action_e;

  typedef enum logic [AddrW-1:0] {
    REG_RBR_THR = 3'd0,
    REG_IER     = 3'd1,
    REG_IIR_FCR = 3'd2,
    REG_LCR     = 3'd3,
    REG_MCR     = 3'd4,
    REG_LSR     = 3'd5,
    REG_MSR     = 3'd6,
    REG_SCR     = 3'd7
  } reg_addr_e;

  localparam logic [ByteW-1:0] MsrFixed = 8'hb0;
  localparam logic [ByteW-1:0] McrFixed = 8'h08;
  localparam logic [ByteW-1:0] IirNone  = 8'h01;
  localparam logic [ByteW-1:0] IirTx    = 8'h02;
  localparam logic [ByteW-1:0] IirRx    = 8'h04;

  // bit positions
  localparam int unsigned LcrDlabBit  = 7;
  localparam int unsigned FcrRxClrBit = 1;
  localparam int unsigned FcrTxClrBit = 2;
  localparam int unsigned FcrDmaBit   = 3;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [AddrW-1:0]   reg_address;
    logic [ByteW-1:0]   write_byte;
    logic [ByteW-1:0]   rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] read_byte;
    logic             irq_line;
    logic             tx_valid;
    logic [ByteW-1:0] tx_byte;
    logic             access_error;
  } out_word_t;

endpackage

`default_nettype wire

### hdl/urm_stream_if.sv
// ----------------------------------------------------------------------------
// UART register model channels
// Valid/ready channels for the action word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface urm_in_if;
  logic                      valid;
  logic                      ready;
  logic [urm_pkg::ActionW-1:0] action;
  logic [urm_pkg::AddrW-1:0]   reg_address;
  logic [urm_pkg::ByteW-1:0]   write_byte;
  logic [urm_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, action, reg_address, write_byte, rx_byte, input ready);
  modport sink   (input valid, action, reg_address, write_byte, rx_byte, output ready);
endinterface

interface urm_out_if;
  logic                      valid;
  logic                      ready;
  logic [urm_pkg::ByteW-1:0] read_byte;
  logic                      irq_line;
  logic                      tx_valid;
  logic [urm_pkg::ByteW-1:0] tx_byte;
  logic                      access_error;

  modport source (output valid, read_byte, irq_line, tx_valid, tx_byte, access_error,
                  input ready);
  modport sink   (input valid, read_byte, irq_line, tx_valid, tx_byte, access_error,
                  output ready);
endinterface

`default_nettype wire

### hdl/uart_register_model_top.sv
// ----------------------------------------------------------------------------
// UART register model top
// 16550-style register block: bus read/write, host receive, poll tick.
// ----------------------------------------------------------------------------
//   channel | dir | word
//   --------+-----+---------------------------------------------------
//   in_i    | in  | action, reg_address, write_byte, rx_byte
//   out_o   | out | read_byte, irq_line, tx_valid, tx_byte, access_error
//
// One word per cycle while the result is not stalled; the path is the input
// register, then the register update and result register in one step.
// State is updated only when a word moves from the input register into the
// result register, so words act in arrival order.
// A stalled result holds; the input register still takes one more word.
// Reset clears all UART state and both valid flags.
`default_nettype none

`include "uart_register_model_top_defines.svh"

module uart_register_model_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  urm_in_if.sink    in_i,
  urm_out_if.source out_o
);
  import urm_pkg::*;

  // input stage
  logic     in_valid_q;
  in_word_t in_q;
  logic     advance;
  logic     out_valid_q;
  out_word_t out_q, out_d;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= '{action: in_i.action, reg_address: in_i.reg_address,
                write_byte: in_i.write_byte, rx_byte: in_i.rx_byte};
    end
  end

  // UART state
  logic [ByteW-1:0] tx_hold_q, tx_hold_d;
  logic             tx_full_q, tx_full_d;
  logic [ByteW-1:0] rx_hold_q, rx_hold_d;
  logic             rx_full_q, rx_full_d;
  logic             rx_ien_q, rx_ien_d;
  logic             tx_ien_q, tx_ien_d;
  logic             tx_acked_q, tx_acked_d;
  logic [ByteW-1:0] lcr_q, lcr_d;
  logic [ByteW-1:0] mcr_q, mcr_d;
  logic [ByteW-1:0] scr_q, scr_d;

  action_e          act;
  reg_addr_e        addr;
  logic             dlab;
  logic [ByteW-1:0] wb;

  assign act  = action_e'(in_q.action);
  assign addr = reg_addr_e'(in_q.reg_address);
  assign dlab = lcr_q[LcrDlabBit];
  assign wb   = in_q.write_byte;

  always_comb begin
    tx_hold_d  = tx_hold_q;
    tx_full_d  = tx_full_q;
    rx_hold_d  = rx_hold_q;
    rx_full_d  = rx_full_q;
    rx_ien_d   = rx_ien_q;
    tx_ien_d   = tx_ien_q;
    tx_acked_d = tx_acked_q;
    lcr_d      = lcr_q;
    mcr_d      = mcr_q;
    scr_d      = scr_q;
    out_d      = '0;

    unique case (act)
      ACT_READ: begin
        unique case (addr)
          REG_RBR_THR: begin
            if (!dlab) begin
              out_d.read_byte = rx_hold_q;
              rx_full_d       = 1'b0;
            end
          end
          REG_IER: begin
            if (!dlab) begin
              out_d.read_byte = {6'b0, tx_ien_q, rx_ien_q};
            end
          end
          REG_IIR_FCR: begin
            if (rx_ien_q && rx_full_q) begin
              out_d.read_byte = IirRx;
            end else if (tx_ien_q && !tx_full_q && !tx_acked_q) begin
              // reading the TX-empty source acknowledges it
              out_d.read_byte = IirTx;
              tx_acked_d      = 1'b1;
            end else begin
              out_d.read_byte = IirNone;
            end
          end
          REG_LCR: out_d.read_byte = lcr_q;
          REG_MCR: out_d.read_byte = McrFixed;
          REG_LSR: out_d.read_byte = {1'b0, !tx_full_q, !tx_full_q, 4'b0, rx_full_q};
          REG_MSR: out_d.read_byte = MsrFixed;
          REG_SCR: out_d.read_byte = scr_q;
          default: out_d.read_byte = '0;
        endcase
      end
      ACT_WRITE: begin
        unique case (addr)
          REG_RBR_THR: begin
            if (!dlab) begin
              tx_hold_d  = wb;
              tx_full_d  = 1'b1;
              tx_acked_d = 1'b0;
            end
          end
          REG_IER: begin
            if (!dlab) begin
              rx_ien_d = wb[0];
              tx_ien_d = wb[1];
            end
          end
          REG_IIR_FCR: begin
            if (wb[FcrDmaBit]) begin
              out_d.access_error = 1'b1;
            end else begin
              if (wb[FcrRxClrBit]) rx_full_d = 1'b0;
              if (wb[FcrTxClrBit]) tx_full_d = 1'b0;
            end
          end
          REG_LCR: lcr_d = wb;
          REG_MCR: mcr_d = wb;
          REG_SCR: scr_d = wb;
          REG_LSR, REG_MSR: out_d.access_error = 1'b1;
          default: out_d.access_error = 1'b1;
        endcase
      end
      ACT_RX: begin
        rx_hold_d = in_q.rx_byte;
        rx_full_d = 1'b1;
      end
      ACT_POLL: begin
        if (tx_full_q) begin
          out_d.tx_valid = 1'b1;
          out_d.tx_byte  = tx_hold_q;
          tx_full_d      = 1'b0;
        end
        // after a drain tx_full is always clear
        out_d.irq_line = (rx_ien_q && rx_full_q) || (tx_ien_q && !tx_acked_q);
      end
      default: out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_hold_q  <= '0;
      tx_full_q  <= 1'b0;
      rx_hold_q  <= '0;
      rx_full_q  <= 1'b0;
      rx_ien_q   <= 1'b0;
      tx_ien_q   <= 1'b0;
      tx_acked_q <= 1'b0;
      lcr_q      <= '0;
      mcr_q      <= '0;
      scr_q      <= '0;
    end else if (advance) begin
      tx_hold_q  <= tx_hold_d;
      tx_full_q  <= tx_full_d;
      rx_hold_q  <= rx_hold_d;
      rx_full_q  <= rx_full_d;
      rx_ien_q   <= rx_ien_d;
      tx_ien_q   <= tx_ien_d;
      tx_acked_q <= tx_acked_d;
      lcr_q      <= lcr_d;
      mcr_q      <= mcr_d;
      scr_q      <= scr_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_byte    = out_q.read_byte;
  assign out_o.irq_line     = out_q.irq_line;
  assign out_o.tx_valid     = out_q.tx_valid;
  assign out_o.tx_byte      = out_q.tx_byte;
  assign out_o.access_error = out_q.access_error;

  // the unused MCR value is kept for completeness of the register set
  logic mcr_unused;
  assign mcr_unused = ^mcr_q;

  `URM_ASSERT_NEXT(a_poll_drains, advance && act == ACT_POLL, !tx_full_q)
  `URM_ASSERT_NEXT(a_in_holds, in_valid_q && !advance, in_valid_q && $stable(in_q))
  `URM_ASSERT_NEXT(a_iir_tx_acks,
                   advance && act == ACT_READ && addr == REG_IIR_FCR &&
                   out_d.read_byte == IirTx,
                   tx_acked_q)
  `URM_ASSERT_IMPL(a_tx_only_on_poll, out_valid_q && out_q.tx_valid,
                   out_q.read_byte == '0 && !out_q.access_error)

endmodule

`default_nettype wire
